### rtl/kbp_pkg.sv
// ----------------------------------------------------------------------------
// kbp_pkg - shared types and constants of the bicycle predictor
// fixed-point constants, arctangent table, beat structs, saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package kbp_pkg;

   // 1/(2*pi) in Q.62, split in two 30-bit halves for the partial products
   localparam logic [59:0] INV_TWO_PI_Q62 = 60'd733972625820500371;
   localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;

   localparam int CORDIC_W = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam int ATAN_DEPTH = 32;

   localparam logic [29:0] ATAN_Q30 [ATAN_DEPTH] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } kbp_quad_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] phi;
      logic signed [31:0] k;
      logic signed [31:0] v;
      logic signed [31:0] a;
      logic [23:0]        dt;
   } kbp_req_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] phi;
      logic signed [31:0] k;
      logic signed [31:0] v;
      logic signed [31:0] a;
      logic               bad;
   } kbp_state_type;

   typedef struct packed {
      kbp_state_type      st;
      logic signed [31:0] spd;
      logic               spd_clip;
      logic signed [56:0] s24;
   } kbp_side_type;

   typedef struct packed {
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic signed [31:0] next_z;
      logic signed [31:0] next_heading;
      logic signed [31:0] next_curvature;
      logic signed [31:0] next_speed;
      logic signed [31:0] next_accel;
      logic               bad_horizon;
      logic               saturated;
   } kbp_rsp_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               clip;
   } kbp_sat_type;

   function automatic kbp_sat_type sat32(input logic signed [65:0] v);
      kbp_sat_type r;
      if (v > 66'sd2147483647) begin
         r.val  = 32'sh7fffffff;
         r.clip = 1'b1;
      end else if (v < -66'sd2147483648) begin
         r.val  = 32'sh80000000;
         r.clip = 1'b1;
      end else begin
         r.val  = 32'(v);
         r.clip = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/kbp_kin.sv
// ----------------------------------------------------------------------------
// kbp_kin - kinematic front end
// distance, speed, midpoint heading, turn fraction and cordic residual angle
// ----------------------------------------------------------------------------
`default_nettype none

module kbp_kin (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire kbp_pkg::kbp_req_type   in_req,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic signed [31:0]          out_angle,
   output kbp_pkg::kbp_quad_type       out_quad,
   output kbp_pkg::kbp_side_type       out_side
);

   localparam int NS = 10;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   rdy;

   kbp_pkg::kbp_side_type sd_ff [NS];
   kbp_pkg::kbp_side_type sd_in [NS];

   // stage 0
   logic [23:0]        dt0_ff, dt0_in;
   logic signed [56:0] dta0_ff, dta0_in, dtv0_ff, dtv0_in;
   // stage 1
   logic [23:0]        dt1_ff;
   logic signed [57:0] w1_ff, w1_in;
   logic signed [40:0] rdta1_ff, rdta1_in;
   logic signed [60:0] pkl1_ff, pkl1_in, pkh1_ff, pkh1_in;
   logic               nk1_ff, nk1_in;
   // stage 2
   logic signed [88:0] pk2_ff, pk2_in;
   logic signed [53:0] ql2_ff, ql2_in, qh2_ff, qh2_in;
   logic               ns2_ff;
   // stage 3
   logic signed [56:0] mid3_ff, mid3_in;
   // stage 4
   logic [58:0]        p00_ff, p00_in, p01_ff, p01_in;
   logic signed [58:0] p10_ff, p10_in, p11_ff, p11_in;
   logic               nt4_ff;
   // stage 5
   logic [85:0]        a5_ff, a5_in, b5_ff, b5_in;
   // stage 6
   logic [31:0]        t6_ff, t6_in;
   // stage 7
   kbp_pkg::kbp_quad_type q7_ff, q7_in, q8_ff, q9_ff;
   logic signed [30:0] f7_ff, f7_in;
   // stage 8
   logic signed [62:0] zp8_ff, zp8_in;
   // stage 9
   logic signed [31:0] z9_ff, z9_in;

   assign vld_in = {vld_ff[NS-2:0], in_valid};
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_comb begin
      kbp_pkg::kbp_sat_type spd_sat;
      logic signed [56:0] rd0;
      logic signed [82:0] sp3;
      logic [85:0]        sum6;
      logic [31:0]        u7;

      sd_in[0].st.x   = in_req.x;
      sd_in[0].st.y   = in_req.y;
      sd_in[0].st.z   = in_req.z;
      sd_in[0].st.phi = in_req.phi;
      sd_in[0].st.k   = in_req.k;
      sd_in[0].st.v   = in_req.v;
      sd_in[0].st.a   = in_req.a;
      sd_in[0].st.bad = (in_req.dt == 24'd0);
      sd_in[0].spd      = '0;
      sd_in[0].spd_clip = 1'b0;
      sd_in[0].s24      = '0;
      for (int i = 1; i < NS; i++) begin
         sd_in[i] = sd_ff[i-1];
      end

      // dt*a and dt*v
      dt0_in  = in_req.dt;
      dta0_in = $signed({1'b0, in_req.dt}) * in_req.a;
      dtv0_in = $signed({1'b0, in_req.dt}) * in_req.v;

      // 2v + dt*a in Q.32, dt*a rounded for speed, dt*v*kappa split in two
      w1_in    = (58'(sd_ff[0].st.v) <<< 17) + 58'(dta0_ff);
      rd0      = dta0_ff + 57'sd32768 - $signed({56'd0, dta0_ff[56]});
      rdta1_in = 41'(rd0 >>> 16);
      pkl1_in  = $signed({1'b0, dtv0_ff[27:0]}) * sd_ff[0].st.k;
      pkh1_in  = $signed(dtv0_ff[56:28]) * sd_ff[0].st.k;
      nk1_in   = (dtv0_ff[56] ^ sd_ff[0].st.k[31]) && (dtv0_ff != '0)
                 && (sd_ff[0].st.k != '0);

      // speed result, kappa product joined, distance partial products
      spd_sat = kbp_pkg::sat32(66'(sd_ff[1].st.v) + 66'(rdta1_ff));
      sd_in[2].spd      = spd_sat.val;
      sd_in[2].spd_clip = spd_sat.clip;
      pk2_in = 89'(pkl1_ff) + (89'(pkh1_ff) <<< 28) + 89'sd4294967296
               - $signed({88'd0, nk1_ff});
      ql2_in = $signed({1'b0, dt1_ff}) * $signed({1'b0, w1_ff[28:0]});
      qh2_in = $signed({1'b0, dt1_ff}) * $signed(w1_ff[57:29]);

      // midpoint heading and distance in Q.24
      mid3_in = 57'(sd_ff[2].st.phi) + 57'(pk2_ff >>> 33);
      sp3 = 83'(ql2_ff) + (83'(qh2_ff) <<< 29) + 83'sd16777216
            - $signed({82'd0, ns2_ff});
      sd_in[3].s24 = 57'(sp3 >>> 25);

      // heading times 1/(2*pi): four partial products
      p00_in = 59'(mid3_ff[28:0]) * 59'(kbp_pkg::INV_TWO_PI_Q62[29:0]);
      p01_in = 59'(mid3_ff[28:0]) * 59'(kbp_pkg::INV_TWO_PI_Q62[59:30]);
      p10_in = $signed(mid3_ff[56:29]) * $signed({1'b0, kbp_pkg::INV_TWO_PI_Q62[29:0]});
      p11_in = $signed(mid3_ff[56:29]) * $signed({1'b0, kbp_pkg::INV_TWO_PI_Q62[59:30]});

      // only the low 86 bits matter for the turn fraction
      a5_in = 86'(p00_ff) + (86'(p01_ff) << 30) + 86'd9007199254740992
              - 86'(nt4_ff);
      b5_in = (86'(p10_ff) << 29) + (86'(p11_ff) << 59);

      sum6  = a5_ff + b5_ff;
      t6_in = sum6[85:54];

      // nearest quarter turn and residual within one eighth turn
      u7    = t6_ff + 32'h2000_0000;
      q7_in = kbp_pkg::kbp_quad_type'(u7[31:30]);
      f7_in = $signed({1'b0, u7[29:0]}) - 31'sd536870912;

      zp8_in = f7_ff * kbp_pkg::HALF_PI_Q30;
      z9_in  = 32'((zp8_ff + 63'sd536870912 - $signed({62'd0, zp8_ff[62]})) >>> 30);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (rdy[i]) begin
            sd_ff[i] <= sd_in[i];
         end
      end
      if (rdy[0]) begin
         dt0_ff  <= dt0_in;
         dta0_ff <= dta0_in;
         dtv0_ff <= dtv0_in;
      end
      if (rdy[1]) begin
         dt1_ff   <= dt0_ff;
         w1_ff    <= w1_in;
         rdta1_ff <= rdta1_in;
         pkl1_ff  <= pkl1_in;
         pkh1_ff  <= pkh1_in;
         nk1_ff   <= nk1_in;
      end
      if (rdy[2]) begin
         pk2_ff <= pk2_in;
         ql2_ff <= ql2_in;
         qh2_ff <= qh2_in;
         ns2_ff <= w1_ff[57];
      end
      if (rdy[3]) begin
         mid3_ff <= mid3_in;
      end
      if (rdy[4]) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         nt4_ff <= mid3_ff[56];
      end
      if (rdy[5]) begin
         a5_ff <= a5_in;
         b5_ff <= b5_in;
      end
      if (rdy[6]) begin
         t6_ff <= t6_in;
      end
      if (rdy[7]) begin
         q7_ff <= q7_in;
         f7_ff <= f7_in;
      end
      if (rdy[8]) begin
         q8_ff  <= q7_ff;
         zp8_ff <= zp8_in;
      end
      if (rdy[9]) begin
         q9_ff <= q8_ff;
         z9_ff <= z9_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_angle = z9_ff;
   assign out_quad  = q9_ff;
   assign out_side  = sd_ff[NS-1];

endmodule

`default_nettype wire

### rtl/kbp_cordic.sv
// ----------------------------------------------------------------------------
// kbp_cordic - unrolled rotation-mode cordic
// one micro-rotation per register stage, quadrant and side data ride along
// ----------------------------------------------------------------------------
`default_nettype none

module kbp_cordic #(
   parameter int STEPS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [31:0]      in_angle,
   input  wire kbp_pkg::kbp_quad_type   in_quad,
   input  wire kbp_pkg::kbp_side_type   in_side,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic signed [kbp_pkg::CORDIC_W-1:0] out_x,
   output logic signed [kbp_pkg::CORDIC_W-1:0] out_y,
   output kbp_pkg::kbp_quad_type        out_quad,
   output kbp_pkg::kbp_side_type        out_side
);

   localparam int CW = kbp_pkg::CORDIC_W;

   logic [STEPS-1:0] vld_ff;
   logic [STEPS-1:0] vld_in;
   logic [STEPS:0]   rdy;

   logic signed [CW-1:0]  x_ff [STEPS];
   logic signed [CW-1:0]  y_ff [STEPS];
   logic signed [CW-1:0]  z_ff [STEPS];
   kbp_pkg::kbp_quad_type q_ff [STEPS];
   kbp_pkg::kbp_side_type sd_ff [STEPS];

   if (STEPS > 1) begin : g_vin
      assign vld_in = {vld_ff[STEPS-2:0], in_valid};
   end else begin : g_vin1
      assign vld_in = in_valid;
   end

   assign rdy[STEPS] = out_ready;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CW-1:0]  xp, yp, zp, xs, ys, at, x_in, y_in, z_in;
      kbp_pkg::kbp_quad_type qp;
      kbp_pkg::kbp_side_type sp;

      if (i == 0) begin : g_first
         assign xp = kbp_pkg::CORDIC_GAIN_Q30;
         assign yp = '0;
         assign zp = CW'(in_angle);
         assign qp = in_quad;
         assign sp = in_side;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign qp = q_ff[i-1];
         assign sp = sd_ff[i-1];
      end

      assign rdy[i] = !vld_ff[i] || rdy[i+1];
      assign xs = xp >>> i;
      assign ys = yp >>> i;
      assign at = $signed({{(CW-30){1'b0}}, kbp_pkg::ATAN_Q30[i]});

      always_comb begin
         if (zp >= 0) begin
            x_in = xp - ys;
            y_in = yp + xs;
            z_in = zp - at;
         end else begin
            x_in = xp + ys;
            y_in = yp - xs;
            z_in = zp + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vld_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            q_ff[i]  <= qp;
            sd_ff[i] <= sp;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[STEPS-1];
   assign out_x     = x_ff[STEPS-1];
   assign out_y     = y_ff[STEPS-1];
   assign out_quad  = q_ff[STEPS-1];
   assign out_side  = sd_ff[STEPS-1];

endmodule

`default_nettype wire

### rtl/kbp_proj.sv
// ----------------------------------------------------------------------------
// kbp_proj - projection and output stage
// quadrant fold, distance times cos/sin/kappa, position and heading update
// ----------------------------------------------------------------------------
`default_nettype none

module kbp_proj (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic signed [kbp_pkg::CORDIC_W-1:0] in_x,
   input  wire logic signed [kbp_pkg::CORDIC_W-1:0] in_y,
   input  wire kbp_pkg::kbp_quad_type   in_quad,
   input  wire kbp_pkg::kbp_side_type   in_side,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output kbp_pkg::kbp_rsp_type         out_rsp
);

   localparam int NS = 5;
   localparam int CW = kbp_pkg::CORDIC_W;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   rdy;

   kbp_pkg::kbp_side_type sd_ff [NS-1];

   logic signed [31:0] c0_ff, c0_in, s0_ff, s0_in;
   logic signed [60:0] xl1_ff, xl1_in, xh1_ff, xh1_in;
   logic signed [60:0] yl1_ff, yl1_in, yh1_ff, yh1_in;
   logic signed [60:0] kl1_ff, kl1_in, kh1_ff, kh1_in;
   logic               nx1_ff, nx1_in, ny1_ff, ny1_in, nk1_ff, nk1_in;
   logic signed [88:0] px2_ff, px2_in, py2_ff, py2_in, pk2_ff, pk2_in;
   logic signed [65:0] sx3_ff, sx3_in, sy3_ff, sy3_in, sh3_ff, sh3_in;
   kbp_pkg::kbp_rsp_type rsp_ff, rsp_in;

   assign vld_in = {vld_ff[NS-2:0], in_valid};
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_comb begin
      logic signed [CW-1:0] cw, sw;
      logic signed [56:0]   d;
      kbp_pkg::kbp_sat_type sx, sy, sh;
      kbp_pkg::kbp_state_type st;

      // quadrant fold by exact swaps and negations
      case (in_quad)
         kbp_pkg::QUAD_0: begin
            cw = in_x;
            sw = in_y;
         end
         kbp_pkg::QUAD_90: begin
            cw = -in_y;
            sw = in_x;
         end
         kbp_pkg::QUAD_180: begin
            cw = -in_x;
            sw = -in_y;
         end
         default: begin
            cw = in_y;
            sw = -in_x;
         end
      endcase
      c0_in = 32'(cw);
      s0_in = 32'(sw);

      // distance split low / high against cos, sin and kappa
      d      = sd_ff[0].s24;
      xl1_in = $signed({1'b0, d[27:0]}) * c0_ff;
      xh1_in = $signed(d[56:28]) * c0_ff;
      yl1_in = $signed({1'b0, d[27:0]}) * s0_ff;
      yh1_in = $signed(d[56:28]) * s0_ff;
      kl1_in = $signed({1'b0, d[27:0]}) * sd_ff[0].st.k;
      kh1_in = $signed(d[56:28]) * sd_ff[0].st.k;
      nx1_in = (d[56] ^ c0_ff[31]) && (d != '0) && (c0_ff != '0);
      ny1_in = (d[56] ^ s0_ff[31]) && (d != '0) && (s0_ff != '0);
      nk1_in = (d[56] ^ sd_ff[0].st.k[31]) && (d != '0) && (sd_ff[0].st.k != '0);

      // join partial products, round half away from zero
      px2_in = 89'(xl1_ff) + (89'(xh1_ff) <<< 28) + 89'sd137438953472
               - $signed({88'd0, nx1_ff});
      py2_in = 89'(yl1_ff) + (89'(yh1_ff) <<< 28) + 89'sd137438953472
               - $signed({88'd0, ny1_ff});
      pk2_in = 89'(kl1_ff) + (89'(kh1_ff) <<< 28) + 89'sd8388608
               - $signed({88'd0, nk1_ff});

      sx3_in = 66'(sd_ff[2].st.x) + 66'(px2_ff >>> 38);
      sy3_in = 66'(sd_ff[2].st.y) + 66'(py2_ff >>> 38);
      sh3_in = 66'(sd_ff[2].st.phi) + 66'(pk2_ff >>> 24);

      // saturate, zero horizon passes the state through
      st = sd_ff[3].st;
      sx = kbp_pkg::sat32(sx3_ff);
      sy = kbp_pkg::sat32(sy3_ff);
      sh = kbp_pkg::sat32(sh3_ff);
      rsp_in.next_x         = st.bad ? st.x : sx.val;
      rsp_in.next_y         = st.bad ? st.y : sy.val;
      rsp_in.next_z         = st.z;
      rsp_in.next_heading   = st.bad ? st.phi : sh.val;
      rsp_in.next_curvature = st.k;
      rsp_in.next_speed     = st.bad ? st.v : sd_ff[3].spd;
      rsp_in.next_accel     = st.a;
      rsp_in.bad_horizon    = st.bad;
      rsp_in.saturated      = !st.bad && (sx.clip || sy.clip || sh.clip
                                          || sd_ff[3].spd_clip);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sd_ff[0] <= in_side;
         c0_ff    <= c0_in;
         s0_ff    <= s0_in;
      end
      if (rdy[1]) begin
         sd_ff[1] <= sd_ff[0];
         xl1_ff <= xl1_in;
         xh1_ff <= xh1_in;
         yl1_ff <= yl1_in;
         yh1_ff <= yh1_in;
         kl1_ff <= kl1_in;
         kh1_ff <= kh1_in;
         nx1_ff <= nx1_in;
         ny1_ff <= ny1_in;
         nk1_ff <= nk1_in;
      end
      if (rdy[2]) begin
         sd_ff[2] <= sd_ff[1];
         px2_ff <= px2_in;
         py2_ff <= py2_in;
         pk2_ff <= pk2_in;
      end
      if (rdy[3]) begin
         sd_ff[3] <= sd_ff[2];
         sx3_ff <= sx3_in;
         sy3_ff <= sy3_in;
         sh3_ff <= sh3_in;
      end
      if (rdy[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

### rtl/kinematic_bicycle_predict_core.sv
// ----------------------------------------------------------------------------
// kinematic_bicycle_predict_core - one-step rear-axle bicycle predictor
// fixed-point forward step with constant acceleration and curvature
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  state + horizon, one beat per item
//   rsp_     out        rsp_valid/rsp_stall  predicted state + flags, one beat
//
// a new beat can enter every cycle while req_stall is low; the pipeline is
// 10 front-end stages, one cordic stage per micro-rotation (CORDIC_STEPS
// capped at 32) and 5 output stages
// reset clears only the stage valid bits, payload registers are not reset
// a stage holds only while it is full and the one after it holds, so bubbles
// close up and req_stall rises only when every stage holds a beat
// ----------------------------------------------------------------------------
`default_nettype none

module kinematic_bicycle_predict_core #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [31:0] req_heading,
   input  wire logic signed [31:0] req_curvature,
   input  wire logic signed [31:0] req_speed,
   input  wire logic signed [31:0] req_accel,
   input  wire logic        [23:0] req_horizon,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_next_x,
   output logic signed [31:0]      rsp_next_y,
   output logic signed [31:0]      rsp_next_z,
   output logic signed [31:0]      rsp_next_heading,
   output logic signed [31:0]      rsp_next_curvature,
   output logic signed [31:0]      rsp_next_speed,
   output logic signed [31:0]      rsp_next_accel,
   output logic                    rsp_bad_horizon,
   output logic                    rsp_saturated
);

   // steps beyond the table length add nothing
   localparam int STEPS = (CORDIC_STEPS > kbp_pkg::ATAN_DEPTH) ?
                          kbp_pkg::ATAN_DEPTH : CORDIC_STEPS;

   kbp_pkg::kbp_req_type  req;
   kbp_pkg::kbp_side_type kin_side, cor_side;
   kbp_pkg::kbp_quad_type kin_quad, cor_quad;
   kbp_pkg::kbp_rsp_type  rsp;

   logic                  kin_ready, kin_valid;
   logic                  cor_ready, cor_valid;
   logic                  prj_ready;
   logic signed [31:0]    kin_angle;
   logic signed [kbp_pkg::CORDIC_W-1:0] cor_x, cor_y;

   assign req.x   = req_pos_x;
   assign req.y   = req_pos_y;
   assign req.z   = req_pos_z;
   assign req.phi = req_heading;
   assign req.k   = req_curvature;
   assign req.v   = req_speed;
   assign req.a   = req_accel;
   assign req.dt  = req_horizon;

   // distance, speed, midpoint heading and residual angle
   kbp_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (kin_ready),
      .in_req    (req),
      .out_valid (kin_valid),
      .out_ready (cor_ready),
      .out_angle (kin_angle),
      .out_quad  (kin_quad),
      .out_side  (kin_side)
   );

   // cos and sin of the residual angle
   kbp_cordic #(
      .STEPS (STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (kin_valid),
      .in_ready  (cor_ready),
      .in_angle  (kin_angle),
      .in_quad   (kin_quad),
      .in_side   (kin_side),
      .out_valid (cor_valid),
      .out_ready (prj_ready),
      .out_x     (cor_x),
      .out_y     (cor_y),
      .out_quad  (cor_quad),
      .out_side  (cor_side)
   );

   // position and heading update, saturation, output register
   kbp_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_ready  (prj_ready),
      .in_x      (cor_x),
      .in_y      (cor_y),
      .in_quad   (cor_quad),
      .in_side   (cor_side),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_rsp   (rsp)
   );

   assign req_stall          = !kin_ready;
   assign rsp_next_x         = rsp.next_x;
   assign rsp_next_y         = rsp.next_y;
   assign rsp_next_z         = rsp.next_z;
   assign rsp_next_heading   = rsp.next_heading;
   assign rsp_next_curvature = rsp.next_curvature;
   assign rsp_next_speed     = rsp.next_speed;
   assign rsp_next_accel     = rsp.next_accel;
   assign rsp_bad_horizon    = rsp.bad_horizon;
   assign rsp_saturated      = rsp.saturated;

endmodule

`default_nettype wire

### dv/tb_kinematic_bicycle_predict_core.sv
// ----------------------------------------------------------------------------
// tb_kinematic_bicycle_predict_core - self-checking bench of the bicycle core
// a queue-fed driver sends state beats, a clocked monitor compares each result
// beat with a bit-exact fixed-point prediction of the forward step
// ----------------------------------------------------------------------------
`default_nettype none

module tb_kinematic_bicycle_predict_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 24;
   localparam int LATENCY = 15 + STEPS;
   localparam int N_RANDOM = 1300;

   localparam longint unsigned MAG_CAP = 64'h4000000000000000;
   localparam longint INV_2PI_Q62 = 64'sd733972625820500371;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint GAIN_Q30 = 64'sd652032874;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_heading = '0, req_curvature = '0;
   logic signed [31:0] req_speed = '0, req_accel = '0;
   logic        [23:0] req_horizon = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_next_x, rsp_next_y, rsp_next_z, rsp_next_heading;
   logic signed [31:0] rsp_next_curvature, rsp_next_speed, rsp_next_accel;
   logic               rsp_bad_horizon, rsp_saturated;

   kinematic_bicycle_predict_core #(.CORDIC_STEPS(STEPS)) dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expectations
   kbp_pkg::kbp_req_type pending_beats[$];
   kbp_pkg::kbp_rsp_type predicted_states[$];

   int  errors = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   int  n_bad_dt = 0;
   int  n_clipped = 0;
   bit  hold_off = 1'b0;   // sender pause until the pipe drains
   bit  quiet = 1'b0;      // last part of the run: no idling at all

   // round(a*b / 2^sh), half away from zero, magnitude capped at 2^62
   function automatic longint round_mul(longint a, longint b, int sh);
      logic [127:0] ua, ub, p, r;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      if (a == 64'sh8000000000000000) ua = 128'h8000000000000000;
      if (b == 64'sh8000000000000000) ub = 128'h8000000000000000;
      p = ua * ub;
      r = (p + (128'd1 << (sh - 1))) >> sh;
      if (r > 128'(MAG_CAP)) r = 128'(MAG_CAP);
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   // cos and sin in Q.30 of an angle in Q.32 turns
   function automatic void rotate_unit(input logic [31:0] t,
                                       output longint c, output longint s);
      logic [31:0]  qsum, d;
      kbp_pkg::kbp_quad_type q;
      longint f, z, x, y, xs, ys;
      qsum = t + 32'h20000000;
      q = kbp_pkg::kbp_quad_type'(qsum[31:30]);
      d = t - {q, 30'd0};
      f = longint'(signed'(d));
      z = round_mul(f, HALF_PI_Q30_L, 30);
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(kbp_pkg::ATAN_Q30[i]);
         end else begin
            x += ys; y -= xs; z += longint'(kbp_pkg::ATAN_Q30[i]);
         end
      end
      case (q)
         kbp_pkg::QUAD_0:   begin c = x;  s = y;  end
         kbp_pkg::QUAD_90:  begin c = -y; s = x;  end
         kbp_pkg::QUAD_180: begin c = -x; s = -y; end
         default:           begin c = y;  s = -x; end
      endcase
   endfunction

   function automatic logic signed [31:0] clip32(longint v, inout bit clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic kbp_pkg::kbp_rsp_type predict_step(kbp_pkg::kbp_req_type r);
      kbp_pkg::kbp_rsp_type o;
      longint x, y, phi, k, v, a, dt, w33, s24, mid, turns, c30, s30;
      bit clipped;
      clipped = 1'b0;
      x = r.x; y = r.y; phi = r.phi; k = r.k; v = r.v; a = r.a;
      dt = longint'({40'd0, r.dt});
      o.next_z = r.z;
      o.next_curvature = r.k;
      o.next_accel = r.a;
      if (dt == 0) begin
         o.next_x = r.x;
         o.next_y = r.y;
         o.next_heading = r.phi;
         o.next_speed = r.v;
         o.bad_horizon = 1'b1;
         o.saturated = 1'b0;
         return o;
      end
      w33 = v * 131072 + dt * a;
      s24 = round_mul(dt, w33, 25);
      mid = phi + round_mul(dt * v, k, 33);
      turns = round_mul(mid, INV_2PI_Q62, 54);
      rotate_unit(turns[31:0], c30, s30);
      o.next_x = clip32(x + round_mul(s24, c30, 38), clipped);
      o.next_y = clip32(y + round_mul(s24, s30, 38), clipped);
      o.next_heading = clip32(phi + round_mul(s24, k, 24), clipped);
      o.next_speed = clip32(v + round_mul(dt, a, 16), clipped);
      o.bad_horizon = 1'b0;
      o.saturated = clipped;
      return o;
   endfunction

   function automatic logic signed [31:0] rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         2: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
         default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   // mostly realistic states, some full-range noise to hit saturation
   function automatic kbp_pkg::kbp_req_type random_state();
      kbp_pkg::kbp_req_type r;
      int wide;
      wide = ($urandom_range(0, 9) < 2) ? 0 : 2;
      r.x = rand_word(($urandom_range(0, 19) == 0) ? 3 : wide);
      r.y = rand_word(($urandom_range(0, 19) == 0) ? 3 : wide);
      r.z = $urandom;
      r.phi = rand_word(($urandom_range(0, 9) == 0) ? 0 : 2);
      r.k = rand_word(($urandom_range(0, 4) == 0) ? 0 : 1);
      r.v = rand_word(($urandom_range(0, 4) == 0) ? 0 : 2);
      r.a = rand_word(($urandom_range(0, 4) == 0) ? 0 : 1);
      case ($urandom_range(0, 9))
         0:       r.dt = '0;
         1:       r.dt = 24'($urandom);
         2:       r.dt = 24'hffffff;
         default: r.dt = 24'($urandom_range(1, 24'h03ffff));
      endcase
      return r;
   endfunction

   task automatic queue_beat(kbp_pkg::kbp_req_type r);
      pending_beats.push_back(r);
      predicted_states.push_back(predict_step(r));
   endtask

   task automatic queue_directed();
      kbp_pkg::kbp_req_type r;
      // zero horizon with extreme state: pass-through and error flag
      r = '{x: 32'sh7fffffff, y: 32'sh80000000, z: 32'sh80000000, phi: 32'sh7fffffff,
            k: 32'sh80000000, v: 32'sh7fffffff, a: 32'sh80000000, dt: 24'd0};
      queue_beat(r);
      r = '{x: '1, y: 0, z: 32'sh7fffffff, phi: 32'sh80000000, k: 32'sh7fffffff,
            v: 32'sh80000000, a: 32'sh7fffffff, dt: 24'd0};
      queue_beat(r);
      // smallest and largest horizon, all-zero state
      r = '0; r.dt = 24'd1;            queue_beat(r);
      r = '0; r.dt = 24'hffffff;       queue_beat(r);
      // straight line at 1 m/s for 1 s
      r = '0; r.v = 32'sh00010000; r.dt = 24'h010000; queue_beat(r);
      // headings across each quadrant, with curvature
      for (int i = -4; i <= 4; i++) begin
         r = '0;
         r.phi = i * 32'sd13176795;   // steps of about 0.785 rad
         r.k = 32'sh00400000;
         r.v = 32'sh00050000;
         r.a = -32'sh00008000;
         r.dt = 24'h008000;
         queue_beat(r);
      end
      // saturation of every predicted field
      r = '{x: 32'sh7fff0000, y: 32'sh7fff0000, z: 0, phi: 32'sh7fffffff,
            k: 32'sh7fffffff, v: 32'sh7fffffff, a: 32'sh7fffffff, dt: 24'hffffff};
      queue_beat(r);
      r = '{x: 32'sh80000000, y: 32'sh80000000, z: '1, phi: 32'sh80000000,
            k: 32'sh7fffffff, v: 32'sh80000000, a: 32'sh80000000, dt: 24'hffffff};
      queue_beat(r);
      // reversing with large curvature magnitude
      r = '{x: 0, y: 0, z: 0, phi: 32'sh01000000, k: 32'sh80000000,
            v: -32'sh00020000, a: 32'sh00010000, dt: 24'h020000};
      queue_beat(r);
      r = '{x: 32'sh55555555, y: 32'shaaaaaaaa, z: 32'sh55555555, phi: 32'shaaaaaaaa,
            k: 32'sh55555555, v: 32'shaaaaaaaa, a: 32'sh55555555, dt: 24'haaaaaa};
      queue_beat(r);
      r = '{x: 32'shaaaaaaaa, y: 32'sh55555555, z: 32'shaaaaaaaa, phi: 32'sh55555555,
            k: 32'shaaaaaaaa, v: 32'sh55555555, a: 32'shaaaaaaaa, dt: 24'h555555};
      queue_beat(r);
   endtask

   // random idle bursts on both sides
   int send_gap = 0;
   int recv_gap = 0;

   // driver: beats from the pending queue, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            void'(pending_beats.pop_front());
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() == 0 || hold_off) begin
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(1, 19);
               req_valid <= 1'b0;
            end else begin
               req_valid     <= 1'b1;
               req_pos_x     <= pending_beats[0].x;
               req_pos_y     <= pending_beats[0].y;
               req_pos_z     <= pending_beats[0].z;
               req_heading   <= pending_beats[0].phi;
               req_curvature <= pending_beats[0].k;
               req_speed     <= pending_beats[0].v;
               req_accel     <= pending_beats[0].a;
               req_horizon   <= pending_beats[0].dt;
            end
         end
      end
   end

   // stall generator on the result side
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= (recv_gap != 0);
      end else if ($urandom_range(0, 15) == 0) begin
         recv_gap = $urandom_range(1, 19);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      kbp_pkg::kbp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_states.size() == 0) begin
            errors++;
            $display("%0t result beat with nothing expected: x %h y %h", $realtime,
                     rsp_next_x, rsp_next_y);
         end else begin
            want = predicted_states.pop_front();
            check_field("next_x", want.next_x, rsp_next_x);
            check_field("next_y", want.next_y, rsp_next_y);
            check_field("next_z", want.next_z, rsp_next_z);
            check_field("next_heading", want.next_heading, rsp_next_heading);
            check_field("next_curvature", want.next_curvature, rsp_next_curvature);
            check_field("next_speed", want.next_speed, rsp_next_speed);
            check_field("next_accel", want.next_accel, rsp_next_accel);
            check_field("bad_horizon", 32'(want.bad_horizon), 32'(rsp_bad_horizon));
            check_field("saturated", 32'(want.saturated), 32'(rsp_saturated));
            n_checked++;
            if (want.bad_horizon) n_bad_dt++;
            if (want.saturated) n_clipped++;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      wait (pending_beats.size() == 0);

      // sender holds off until the pipeline has drained completely
      hold_off = 1'b1;
      wait (predicted_states.size() == 0);
      hold_off = 1'b0;

      for (int i = 0; i < N_RANDOM; i++) begin
         queue_beat(random_state());
         if (i == N_RANDOM - 200) begin
            wait (pending_beats.size() == 0);
            quiet = 1'b1;
         end
      end
      wait (pending_beats.size() == 0);
      wait (predicted_states.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);

      $display("checked %0d result beats from %0d sent states", n_checked, n_sent);
      $display("zero-horizon beats %0d, saturated results %0d", n_bad_dt, n_clipped);
      if (errors == 0 && predicted_states.size() == 0) begin
         $display("** kinematic_bicycle_predict_core: PASSED **");
      end else begin
         $display("** kinematic_bicycle_predict_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("timeout: %0d beats still expected", predicted_states.size());
      $display("** kinematic_bicycle_predict_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
